// ===== src/qapf_pkg.sv =====
package qapf_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int RESULT_OFFSET_W = 16;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  localparam logic REG_PATTERN_BYTES  = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
  localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_DELTA     = 8'h20;

  typedef struct packed {
    logic shift;
    logic clear;
  } qapf_step_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// ===== src/qapf_quote.sv =====
module qapf_quote
  import qapf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  qapf_step_t step,
  input  logic [7:0] text_byte,
  output logic       elig
);

  logic [7:0] open_quote, open_quote_next;
  logic       escape_pending, escape_pending_next;

  always_comb begin
    open_quote_next     = open_quote;
    escape_pending_next = escape_pending;
    elig                = 1'b0;
    if (text_byte == open_quote) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else begin
        open_quote_next = '0;
      end
    end else if (open_quote != '0) begin
      escape_pending_next = !escape_pending && (text_byte == CHAR_BACKSLASH);
    end else if (text_byte == CHAR_DQUOTE || text_byte == CHAR_SQUOTE ||
                 text_byte == CHAR_BACKTICK) begin
      open_quote_next = text_byte;
    end else begin
      elig = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_quote     <= '0;
      escape_pending <= 1'b0;
    end else if (step.shift) begin
      if (step.clear) begin
        open_quote     <= '0;
        escape_pending <= 1'b0;
      end else begin
        open_quote     <= open_quote_next;
        escape_pending <= escape_pending_next;
      end
    end
  end

endmodule

// ===== src/qapf_cell.sv =====
module qapf_cell
  import qapf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  qapf_step_t step,
  input  logic [7:0] byte_in,
  input  logic       elig_in,
  input  logic [7:0] pat_byte,
  input  logic       in_use,
  output logic [7:0] byte_q,
  output logic       elig_q,
  output logic       hit
);

  logic [7:0] held_byte;
  logic       held_elig;

  // compares the byte about to enter this cell
  assign hit    = !in_use || (fold_case(byte_in) == fold_case(pat_byte));
  assign byte_q = held_byte;
  assign elig_q = held_elig;

  always_ff @(posedge clk) begin
    if (step.shift) begin
      held_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_elig <= 1'b0;
    end else if (step.shift) begin
      held_elig <= step.clear ? 1'b0 : elig_in;
    end
  end

endmodule

// ===== src/quote_aware_pattern_finder_unit.sv =====
// Channel  Direction  Handshake                  Payload
// text     in         text_valid / text_stall    text_byte, end_of_string
// result   out        result_valid / result_stall found, match_offset
// config   in         APB (psel, penable, ...)   pattern_bytes @0, pattern_length @8
//
// One item a cycle while text_stall is low: the window is a row of PATTERN_MAX cells shifted per byte,
// and all cells compare against the pattern in the same cycle.
// The result of a string is registered in the cycle after its last byte is accepted.
// text_stall is high only while a result is held and result_stall is high.
// Synchronous active-high reset; no clearing pass is needed.
module quote_aware_pattern_finder_unit
  import qapf_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       text_valid,
  output logic                       text_stall,
  input  logic [7:0]                 text_byte,
  input  logic                       end_of_string,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       found,
  output logic [RESULT_OFFSET_W-1:0] match_offset,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
  localparam int IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;

  logic       accept;
  qapf_step_t step;
  logic       elig;

  logic [7:0] in_byte [0:PATTERN_MAX-1];
  logic       in_elig [0:PATTERN_MAX-1];
  logic [7:0] pat_sel [0:PATTERN_MAX-1];
  logic [7:0] pat     [0:PATTERN_MAX-1];
  logic [PATTERN_MAX-1:0] in_use;
  logic [PATTERN_MAX-1:0] hit;

  logic [LEN_BITS-1:0] len;
  logic [LEN_BITS-1:0] lm1;

  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic                   match_seen, match_seen_next;
  logic [OFFSET_BITS-1:0] match_start, match_start_next;
  logic [OFFSET_BITS-1:0] cand_start;
  logic                   match_now;
  logic [OFFSET_BITS-1:0] result_value;
  logic [RESULT_OFFSET_W-1:0] result_narrow;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_PATTERN_LENGTH) ? {60'd0, pattern_length} : pattern_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3])
        REG_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  assign len = (pattern_length > 4'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                  : pattern_length[LEN_BITS-1:0];
  assign lm1 = (len == '0) ? '0 : len - LEN_BITS'(1);

  // handshake
  assign text_stall  = result_valid && result_stall;
  assign accept      = text_valid && !text_stall;
  assign step.shift  = accept;
  assign step.clear  = end_of_string;

  qapf_quote u_quote (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (text_byte),
    .elig      (elig)
  );

  // pattern byte each cell must see: cell j holds window entry j
  always_comb begin
    logic [LEN_BITS-1:0] k;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pat[j] = pattern_bytes[8*j +: 8];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      in_use[j] = LEN_BITS'(j) < len;
      k         = lm1 - LEN_BITS'(j);
      pat_sel[j] = pat[k[IDX_BITS-1:0]];
    end
  end

  assign in_byte[0] = text_byte;
  assign in_elig[0] = elig;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    if (j < PATTERN_MAX - 1) begin : g_mid
      qapf_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .step     (step),
        .byte_in  (in_byte[j]),
        .elig_in  (in_elig[j]),
        .pat_byte (pat_sel[j]),
        .in_use   (in_use[j]),
        .byte_q   (in_byte[j+1]),
        .elig_q   (in_elig[j+1]),
        .hit      (hit[j])
      );
    end else begin : g_last
      qapf_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .step     (step),
        .byte_in  (in_byte[j]),
        .elig_in  (in_elig[j]),
        .pat_byte (pat_sel[j]),
        .in_use   (in_use[j]),
        .byte_q   (),
        .elig_q   (),
        .hit      (hit[j])
      );
    end
  end

  // match and offset tracking
  assign match_now = !match_seen &&
                     ((len == '0) ? elig : (in_elig[lm1[IDX_BITS-1:0]] && (&hit)));

  assign cand_start = (byte_offset == OFF_MAX || byte_offset < OFFSET_BITS'(lm1))
                      ? OFF_MAX : byte_offset - OFFSET_BITS'(lm1);

  assign match_seen_next  = match_seen || match_now;
  assign match_start_next = match_now ? cand_start : match_start;
  assign byte_offset_next = (byte_offset == OFF_MAX) ? byte_offset
                                                     : byte_offset + OFFSET_BITS'(1);
  assign result_value     = match_seen_next ? match_start_next : byte_offset_next;

  if (OFFSET_BITS >= RESULT_OFFSET_W) begin : g_trunc
    assign result_narrow = result_value[RESULT_OFFSET_W-1:0];
  end else begin : g_ext
    assign result_narrow = {{(RESULT_OFFSET_W-OFFSET_BITS){1'b0}}, result_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      match_seen  <= 1'b0;
      match_start <= '0;
    end else if (accept) begin
      if (end_of_string) begin
        byte_offset <= '0;
        match_seen  <= 1'b0;
        match_start <= '0;
      end else begin
        byte_offset <= byte_offset_next;
        match_seen  <= match_seen_next;
        match_start <= match_start_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && end_of_string) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_string) begin
      found        <= match_seen_next;
      match_offset <= result_narrow;
    end
  end

  a_new_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(accept && end_of_string))
    else $error("result raised without a final item");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_string) |=> (byte_offset == '0 && !match_seen))
    else $error("string state not cleared after final item");

  a_held_result_blocks: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("held result dropped while stalled");

  a_match_sticky: assert property (@(posedge clk) disable iff (rst)
    (match_seen && !(accept && end_of_string)) |=> match_seen)
    else $error("match flag lost within a string");

endmodule
